FILE: rtl/brc_pkg.sv
// Shared types and constants for the bitmap range-clear / find-bit block.
// No dependencies; used by the bit-search unit and the top level.
`default_nettype none

package brc_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIDX_W    = 5;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [BIDX_W-1:0]    bidx_t;

    // request codes
    localparam int OP_W = 3;
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_CLEAR_RANGE = 3'd0;
    localparam op_t OP_SET_ALL     = 3'd1;
    localparam op_t OP_CLEAR_ALL   = 3'd2;
    localparam op_t OP_FIND_FIRST  = 3'd3;
    localparam op_t OP_FIND_LAST   = 3'd4;

    // priority encoder masks
    localparam word_t ENC_MASK_16 = 32'hFFFF0000;
    localparam word_t ENC_MASK_8  = 32'hFF00FF00;
    localparam word_t ENC_MASK_4  = 32'hF0F0F0F0;
    localparam word_t ENC_MASK_2  = 32'hCCCCCCCC;
    localparam word_t ENC_MASK_1  = 32'hAAAAAAAA;

endpackage

`default_nettype wire

FILE: rtl/brc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [AW-1:0]            raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/brc_lsb_unit.sv
// Shared bit-search unit: lowest set bit of a word, or highest when reversed.
// Depends on brc_pkg.
`default_nettype none

module brc_lsb_unit (
    input  wire brc_pkg::word_t data,
    input  wire logic           reverse,
    output logic                any,
    output brc_pkg::bidx_t      index
);

    brc_pkg::word_t w;
    brc_pkg::word_t x;
    brc_pkg::bidx_t a;

    always_comb
    begin
        for (int i = 0; i < brc_pkg::WORD_BITS; i++)
        begin
            w[i] = reverse ? data[brc_pkg::WORD_BITS-1-i] : data[i];
        end
        x = w & (~w + brc_pkg::word_t'(1));
        a[4] = |(x & brc_pkg::ENC_MASK_16);
        a[3] = |(x & brc_pkg::ENC_MASK_8);
        a[2] = |(x & brc_pkg::ENC_MASK_4);
        a[1] = |(x & brc_pkg::ENC_MASK_2);
        a[0] = |(x & brc_pkg::ENC_MASK_1);
    end

    assign any   = |data;
    // bit-reversed position maps back as 31 - a
    assign index = reverse ? ~a : a;

endmodule

`default_nettype wire

FILE: rtl/bitmap_range_clear_find_bit.sv
// Bitmap with range clear, set/clear all and first/last bit search.
// Set/clear all writes every word in turn. Range clear and searches read the words visited,
//   one RAM read per cycle; searches evaluate each word in the shared bit-search unit.
// One request at a time: a new request is taken only after the previous result is posted.
// Reset: async active low; a wipe pass zeroes the store before the first request
//   is taken. size_in_use resets to NBITS.
`default_nettype none

module bitmap_range_clear_find_bit #(
    parameter int NBITS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // start_index[9:0], end_index[19:10],
                                        // wanted_value[20], zero pad [23:21]
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // found[0], bit_position[10:1], zero pad [15:11]
    // size_in_use register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    localparam int NWORDS = (NBITS + brc_pkg::WORD_BITS - 1) / brc_pkg::WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SW     = (NBITS + 1 > 2048) ? $clog2(NBITS + 1) : 11;
    localparam int CW     = 32;   // compare width for bit indexes

    localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);
    localparam logic [CW-1:0] NB        = CW'(NBITS);
    localparam logic [CW-1:0] LAST_BIT  = CW'(NBITS - 1);

    // sequencer states
    localparam logic [2:0] ST_WIPE = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_FILL = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_POST = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [SW-1:0]    size_reg;

    // request context
    brc_pkg::op_t     op_reg, op_next;
    logic             want_reg, want_next;
    logic             down_reg, down_next;
    brc_pkg::bidx_t   first_off_reg, first_off_next;
    brc_pkg::bidx_t   last_off_reg, last_off_next;
    logic [AW-1:0]    end_reg, end_next;
    brc_pkg::word_t   fill_reg, fill_next;

    // read issue pointer and the word in flight
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic             issue_reg, issue_next;
    logic             first_issue_reg, first_issue_next;
    logic             p_valid_reg, p_valid_next;
    logic [AW-1:0]    p_addr_reg, p_addr_next;
    logic             p_first_reg, p_first_next;
    logic             p_last_reg, p_last_next;

    // pending result and output register
    logic             res_found_reg, res_found_next;
    logic [9:0]       res_pos_reg, res_pos_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [9:0]       m_pos_reg, m_pos_next;

    // RAM port
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr;
    brc_pkg::word_t   ram_wdata, ram_rdata;

    // datapath
    brc_pkg::word_t   sel_word, keep_mask, clr_mask, enc_in;
    logic             enc_any;
    brc_pkg::bidx_t   enc_idx;
    logic [CW-1:0]    hit_idx;

    // request fields
    brc_pkg::op_t     req;
    logic [9:0]       s_idx, e_idx;
    logic             want_in;
    logic [CW-1:0]    s32, e32, ec32, ic32;

    assign req     = brc_pkg::op_t'(s_tuser);
    assign s_idx   = s_tdata[9:0];
    assign e_idx   = s_tdata[19:10];
    assign want_in = s_tdata[20];
    assign s32     = CW'(s_idx);
    assign e32     = CW'(e_idx);
    assign ec32    = (e32 >= NB) ? LAST_BIT : e32;
    assign ic32    = (s32 >= NB) ? LAST_BIT : s32;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'd0, m_pos_reg, m_found_reg};

    brc_ram #(
        .WIDTH (brc_pkg::WORD_BITS),
        .DEPTH (NWORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    brc_lsb_unit u_lsb (
        .data    (enc_in),
        .reverse (down_reg),
        .any     (enc_any),
        .index   (enc_idx)
    );

    // Word in flight: masks for the first and last word of the range
    always_comb
    begin
        sel_word  = want_reg ? ram_rdata : ~ram_rdata;
        keep_mask = '1;
        if (p_first_reg)
        begin
            // find last keeps bits at or below the start, find first at or above
            keep_mask = down_reg ? ('1 >> (~first_off_reg)) : ('1 << first_off_reg);
        end
        clr_mask = (p_first_reg ? ('1 << first_off_reg) : '1)
                 & (p_last_reg ? ('1 >> (~last_off_reg)) : '1);
        enc_in   = sel_word & keep_mask;
        hit_idx  = CW'({p_addr_reg, enc_idx});
    end

    // RAM write port: wipe, fill, or range-clear write-back
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = fill_reg;
        ram_re    = (state_reg == ST_SCAN) && issue_reg;
        unique case (state_reg)
            ST_WIPE:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
            end
            ST_SCAN:
            begin
                if (p_valid_reg && (op_reg == brc_pkg::OP_CLEAR_RANGE))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = p_addr_reg;
                    ram_wdata = ram_rdata & ~clr_mask;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        want_next        = want_reg;
        down_next        = down_reg;
        first_off_next   = first_off_reg;
        last_off_next    = last_off_reg;
        end_next         = end_reg;
        fill_next        = fill_reg;
        ptr_next         = ptr_reg;
        issue_next       = issue_reg;
        first_issue_next = first_issue_reg;
        p_valid_next     = 1'b0;
        p_addr_next      = p_addr_reg;
        p_first_next     = p_first_reg;
        p_last_next      = p_last_reg;
        res_found_next   = res_found_reg;
        res_pos_next     = res_pos_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_found_next     = m_found_reg;
        m_pos_next       = m_pos_reg;

        unique case (state_reg)
            ST_WIPE, ST_FILL:
            begin
                if (ptr_reg == LAST_WORD)
                begin
                    ptr_next   = '0;
                    state_next = (state_reg == ST_WIPE) ? ST_IDLE : ST_POST;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next          = req;
                    want_next        = want_in;
                    down_next        = 1'b0;
                    res_found_next   = 1'b0;
                    res_pos_next     = '0;
                    issue_next       = 1'b1;
                    first_issue_next = 1'b1;
                    state_next       = ST_POST;
                    unique case (req)
                        brc_pkg::OP_CLEAR_RANGE:
                        begin
                            // reversed or out-of-store ranges are ignored
                            if (!(s32 > e32) && (s32 < NB))
                            begin
                                ptr_next       = AW'(s32 >> brc_pkg::BIDX_W);
                                end_next       = AW'(ec32 >> brc_pkg::BIDX_W);
                                first_off_next = s_idx[4:0];
                                last_off_next  = ec32[4:0];
                                state_next     = ST_SCAN;
                            end
                        end
                        brc_pkg::OP_SET_ALL, brc_pkg::OP_CLEAR_ALL:
                        begin
                            ptr_next   = '0;
                            fill_next  = (req == brc_pkg::OP_SET_ALL) ? '1 : '0;
                            state_next = ST_FILL;
                        end
                        brc_pkg::OP_FIND_FIRST:
                        begin
                            if ((s32 < CW'(size_reg)) && (s32 < NB))
                            begin
                                ptr_next       = AW'(s32 >> brc_pkg::BIDX_W);
                                end_next       = LAST_WORD;
                                first_off_next = s_idx[4:0];
                                last_off_next  = '1;
                                state_next     = ST_SCAN;
                            end
                        end
                        brc_pkg::OP_FIND_LAST:
                        begin
                            // start clamps to the top bit; scan runs down to word 0
                            ptr_next       = AW'(ic32 >> brc_pkg::BIDX_W);
                            end_next       = '0;
                            first_off_next = ic32[4:0];
                            last_off_next  = '1;
                            down_next      = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_POST;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue stage: one word read per cycle
                if (issue_reg)
                begin
                    p_valid_next     = 1'b1;
                    p_addr_next      = ptr_reg;
                    p_first_next     = first_issue_reg;
                    p_last_next      = (ptr_reg == end_reg);
                    first_issue_next = 1'b0;
                    if (ptr_reg == end_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = down_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
                    end
                end
                // evaluate stage: word returned by the RAM
                if (p_valid_reg)
                begin
                    if ((op_reg != brc_pkg::OP_CLEAR_RANGE) && enc_any)
                    begin
                        // find first drops hits past the in-use size
                        if (down_reg || ((hit_idx < CW'(size_reg)) && (hit_idx < NB)))
                        begin
                            res_found_next = 1'b1;
                            res_pos_next   = hit_idx[9:0];
                        end
                        issue_next   = 1'b0;
                        p_valid_next = 1'b0;
                        state_next   = ST_POST;
                    end
                    else if (p_last_reg)
                    begin
                        issue_next   = 1'b0;
                        p_valid_next = 1'b0;
                        state_next   = ST_POST;
                    end
                end
            end

            ST_POST:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_pos_next   = res_pos_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_WIPE;
            ptr_reg         <= '0;
            issue_reg       <= 1'b0;
            first_issue_reg <= 1'b0;
            p_valid_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            size_reg        <= SW'(NBITS);
        end
        else
        begin
            state_reg       <= state_next;
            ptr_reg         <= ptr_next;
            issue_reg       <= issue_next;
            first_issue_reg <= first_issue_next;
            p_valid_reg     <= p_valid_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= SW'(cfg_data);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        want_reg      <= want_next;
        down_reg      <= down_next;
        first_off_reg <= first_off_next;
        last_off_reg  <= last_off_next;
        end_reg       <= end_next;
        fill_reg      <= fill_next;
        p_addr_reg    <= p_addr_next;
        p_first_reg   <= p_first_next;
        p_last_reg    <= p_last_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

endmodule

`default_nettype wire
